[rtl/sat_pkg.sv]
// Shared codes, constants and handoff types of the sensor-averaging thermostat.
`default_nettype none
package sat_pkg;

  // Operation codes. Code three falls through to evaluate-only.
  localparam logic [1:0] OP_EVAL   = 2'd0;
  localparam logic [1:0] OP_ADD    = 2'd1;
  localparam logic [1:0] OP_UPDATE = 2'd2;

  // Sensor kinds accepted by an add.
  localparam logic [7:0] KIND_TEMP = 8'd1;
  localparam logic [7:0] KIND_HUM  = 8'd2;

  // Operation status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_KIND = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_BAD_SLOT = 2'd3;

  // Flag change codes.
  localparam logic [1:0] CHG_NONE = 2'd0;
  localparam logic [1:0] CHG_HEAT = 2'd1;
  localparam logic [1:0] CHG_HUM  = 2'd2;

  // Configuration register indexes.
  localparam int CFG_INDEX_BITS = 1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_TEMP = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET_HUM  = 1'd1;

  // Target reset values in Q8.8: 19.0 degrees and 50.0 percent.
  localparam int TARGET_TEMP_RESET = 4864;
  localparam int TARGET_HUM_RESET  = 12800;

  localparam int SLOT_USED_BITS = 4;

  typedef struct packed {
    logic [1:0]                status;
    logic [SLOT_USED_BITS-1:0] used;
  } op_result_t;

  typedef struct packed {
    logic [1:0] change;
    logic       heating;
    logic       humidifying;
  } flag_result_t;

endpackage
`default_nettype wire

[rtl/sat_table.sv]
// Sensor slot table with running per-kind sums and counts.
`default_nettype none
module sat_table #(
  parameter int SENSOR_SLOTS = 5,
  parameter int VALUE_BITS   = 16,
  parameter int CNT_BITS     = 3,
  parameter int SUM_BITS     = 19
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         commit,
  input  wire logic [1:0]                   operation,
  input  wire logic [7:0]                   sensor_kind,
  input  wire logic [7:0]                   slot_index,
  input  wire logic signed [VALUE_BITS-1:0] sample_value,
  output sat_pkg::op_result_t               op_result,
  output logic signed [SUM_BITS-1:0]        temp_sum_next,
  output logic signed [SUM_BITS-1:0]        hum_sum_next,
  output logic [CNT_BITS-1:0]               temp_cnt_next,
  output logic [CNT_BITS-1:0]               hum_cnt_next
);

  localparam int IDX_BITS = (SENSOR_SLOTS > 1) ? $clog2(SENSOR_SLOTS) : 1;

  logic signed [VALUE_BITS-1:0] slot_value [SENSOR_SLOTS];
  logic                         slot_is_hum [SENSOR_SLOTS];
  logic [SENSOR_SLOTS-1:0]      slot_valid;
  logic signed [SUM_BITS-1:0]   temp_sum;
  logic signed [SUM_BITS-1:0]   hum_sum;
  logic [CNT_BITS-1:0]          temp_cnt;
  logic [CNT_BITS-1:0]          hum_cnt;

  logic                         found;
  logic [IDX_BITS-1:0]          free_idx;
  logic [IDX_BITS-1:0]          upd_idx;
  logic                         upd_ok;
  logic                         kind_ok;
  logic                         is_hum_add;
  logic signed [SUM_BITS-1:0]   sample_ext;
  logic signed [SUM_BITS-1:0]   old_ext;
  logic                         wr_en;
  logic                         wr_new;
  logic [IDX_BITS-1:0]          wr_idx;

  // Lowest free slot.
  always_comb begin
    found    = 1'b0;
    free_idx = '0;
    for (int i = 0; i < SENSOR_SLOTS; i++) begin
      if (!found && !slot_valid[i]) begin
        found    = 1'b1;
        free_idx = IDX_BITS'(i);
      end
    end
  end

  assign upd_idx    = slot_index[IDX_BITS-1:0];
  assign upd_ok     = (int'(slot_index) < SENSOR_SLOTS) && slot_valid[upd_idx];
  assign kind_ok    = (sensor_kind == sat_pkg::KIND_TEMP) || (sensor_kind == sat_pkg::KIND_HUM);
  assign is_hum_add = (sensor_kind == sat_pkg::KIND_HUM);
  assign sample_ext = {{(SUM_BITS-VALUE_BITS){sample_value[VALUE_BITS-1]}}, sample_value};
  assign old_ext    = {{(SUM_BITS-VALUE_BITS){slot_value[upd_idx][VALUE_BITS-1]}},
                       slot_value[upd_idx]};

  always_comb begin
    op_result.status = sat_pkg::ST_OK;
    op_result.used   = '0;
    temp_sum_next    = temp_sum;
    hum_sum_next     = hum_sum;
    temp_cnt_next    = temp_cnt;
    hum_cnt_next     = hum_cnt;
    wr_en            = 1'b0;
    wr_new           = 1'b0;
    wr_idx           = upd_idx;
    unique case (operation)
      sat_pkg::OP_ADD: begin
        if (!kind_ok) begin
          op_result.status = sat_pkg::ST_BAD_KIND;
        end else if (!found) begin
          op_result.status = sat_pkg::ST_FULL;
        end else begin
          wr_en          = 1'b1;
          wr_new         = 1'b1;
          wr_idx         = free_idx;
          op_result.used = sat_pkg::SLOT_USED_BITS'(free_idx);
          if (is_hum_add) begin
            hum_sum_next = hum_sum + sample_ext;
            hum_cnt_next = CNT_BITS'(hum_cnt + 1'b1);
          end else begin
            temp_sum_next = temp_sum + sample_ext;
            temp_cnt_next = CNT_BITS'(temp_cnt + 1'b1);
          end
        end
      end
      sat_pkg::OP_UPDATE: begin
        if (!upd_ok) begin
          op_result.status = sat_pkg::ST_BAD_SLOT;
        end else begin
          wr_en          = 1'b1;
          op_result.used = sat_pkg::SLOT_USED_BITS'(upd_idx);
          if (slot_is_hum[upd_idx]) begin
            hum_sum_next = hum_sum - old_ext + sample_ext;
          end else begin
            temp_sum_next = temp_sum - old_ext + sample_ext;
          end
        end
      end
      default: begin
        // evaluate only
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      temp_sum   <= '0;
      hum_sum    <= '0;
      temp_cnt   <= '0;
      hum_cnt    <= '0;
    end else if (commit) begin
      temp_sum <= temp_sum_next;
      hum_sum  <= hum_sum_next;
      temp_cnt <= temp_cnt_next;
      hum_cnt  <= hum_cnt_next;
      if (wr_en && wr_new) begin
        slot_valid[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit && wr_en) begin
      slot_value[wr_idx] <= sample_value;
      if (wr_new) begin
        slot_is_hum[wr_idx] <= is_hum_add;
      end
    end
  end

endmodule
`default_nettype wire

[rtl/sat_control.sv]
// Heater and humidifier flags, checked against target times count.
`default_nettype none
module sat_control #(
  parameter int VALUE_BITS = 16,
  parameter int CNT_BITS   = 3,
  parameter int SUM_BITS   = 19
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         commit,
  input  wire logic signed [VALUE_BITS-1:0] target_temp,
  input  wire logic signed [VALUE_BITS-1:0] target_hum,
  input  wire logic signed [SUM_BITS-1:0]   temp_sum,
  input  wire logic signed [SUM_BITS-1:0]   hum_sum,
  input  wire logic [CNT_BITS-1:0]          temp_cnt,
  input  wire logic [CNT_BITS-1:0]          hum_cnt,
  output sat_pkg::flag_result_t             flags
);

  logic                       heater;
  logic                       humidifier;
  logic signed [SUM_BITS-1:0] temp_limit;
  logic signed [SUM_BITS-1:0] hum_limit;
  logic                       heat_now;
  logic                       hum_now;
  logic                       heat_flip;

  // Average below target, without a divide: sum < target * count.
  assign temp_limit = SUM_BITS'(target_temp) * SUM_BITS'($signed({1'b0, temp_cnt}));
  assign hum_limit  = SUM_BITS'(target_hum) * SUM_BITS'($signed({1'b0, hum_cnt}));
  assign heat_now   = temp_sum < temp_limit;
  assign hum_now    = hum_sum < hum_limit;
  assign heat_flip  = (temp_cnt != '0) && (heat_now != heater);

  always_comb begin
    flags.change      = sat_pkg::CHG_NONE;
    flags.heating     = heater;
    flags.humidifying = humidifier;
    if (temp_cnt != '0) begin
      flags.heating = heat_now;
    end
    if (heat_flip) begin
      flags.change = sat_pkg::CHG_HEAT;
    end else if (hum_cnt != '0) begin
      // skip humidity when heating flipped on this word
      flags.humidifying = hum_now;
      if (hum_now != humidifier) begin
        flags.change = sat_pkg::CHG_HUM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      heater     <= 1'b0;
      humidifier <= 1'b0;
    end else if (commit) begin
      heater     <= flags.heating;
      humidifier <= flags.humidifying;
    end
  end

endmodule
`default_nettype wire

[rtl/sensor_average_thermostat.sv]
// Top level of the sensor-averaging thermostat: input stage, result stage, targets.
//
//   channel   signals                                  direction  width
//   item      item_valid, item_stall, operation,       in         2+8+8+VALUE_BITS
//             sensor_kind, slot_index, sample_value
//   result    result_valid, result_stall, op_status,   out        2+4+2+1+1
//             slot_used, change_code, heating, humidifying
//   config    cfg_write, cfg_index, cfg_data           in         1+1+VALUE_BITS
//
// One word per cycle while no result word is stalled; a taken word moves from the input register
// into the result register, which raises result_valid. The table update and flag check are
// combinational between the input register and the result register.
// The table, sums and flags advance as a word moves into the result register.
// Reset (synchronous) clears slot valid bits, sums, counts, flags and both stages.
// A stalled result holds; the input register keeps taking a word while the result
// register drains, and item_stall rises only when both are full and result_stall is high.
`default_nettype none
module sensor_average_thermostat #(
  parameter int SENSOR_SLOTS = 5,
  parameter int VALUE_BITS   = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  cfg_write,
  input  wire logic [sat_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
  input  wire logic [VALUE_BITS-1:0]                 cfg_data,
  input  wire logic                                  item_valid,
  output logic                                       item_stall,
  input  wire logic [1:0]                            operation,
  input  wire logic [7:0]                            sensor_kind,
  input  wire logic [7:0]                            slot_index,
  input  wire logic signed [VALUE_BITS-1:0]          sample_value,
  output logic                                       result_valid,
  input  wire logic                                  result_stall,
  output logic [1:0]                                 op_status,
  output logic [sat_pkg::SLOT_USED_BITS-1:0]         slot_used,
  output logic [1:0]                                 change_code,
  output logic                                       heating,
  output logic                                       humidifying
);

  localparam int CNT_BITS = $clog2(SENSOR_SLOTS + 1);
  localparam int SUM_BITS = VALUE_BITS + CNT_BITS;

  logic signed [VALUE_BITS-1:0] target_temp;
  logic signed [VALUE_BITS-1:0] target_hum;

  logic                         s1_valid;
  logic [1:0]                   s1_op;
  logic [7:0]                   s1_kind;
  logic [7:0]                   s1_idx;
  logic signed [VALUE_BITS-1:0] s1_sample;

  logic                         advance;
  logic                         take;

  sat_pkg::op_result_t          op_result;
  sat_pkg::flag_result_t        flags;
  logic signed [SUM_BITS-1:0]   temp_sum_next;
  logic signed [SUM_BITS-1:0]   hum_sum_next;
  logic [CNT_BITS-1:0]          temp_cnt_next;
  logic [CNT_BITS-1:0]          hum_cnt_next;

  assign advance    = s1_valid && !(result_valid && result_stall);
  assign item_stall = s1_valid && !advance;
  assign take       = item_valid && !item_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      target_temp <= VALUE_BITS'(sat_pkg::TARGET_TEMP_RESET);
      target_hum  <= VALUE_BITS'(sat_pkg::TARGET_HUM_RESET);
    end else if (cfg_write) begin
      unique case (cfg_index)
        sat_pkg::REG_TARGET_TEMP: target_temp <= cfg_data;
        sat_pkg::REG_TARGET_HUM:  target_hum  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (take) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_op     <= operation;
      s1_kind   <= sensor_kind;
      s1_idx    <= slot_index;
      s1_sample <= sample_value;
    end
  end

  sat_table #(
    .SENSOR_SLOTS (SENSOR_SLOTS),
    .VALUE_BITS   (VALUE_BITS),
    .CNT_BITS     (CNT_BITS),
    .SUM_BITS     (SUM_BITS)
  ) u_table (
    .clk           (clk),
    .rst           (rst),
    .commit        (advance),
    .operation     (s1_op),
    .sensor_kind   (s1_kind),
    .slot_index    (s1_idx),
    .sample_value  (s1_sample),
    .op_result     (op_result),
    .temp_sum_next (temp_sum_next),
    .hum_sum_next  (hum_sum_next),
    .temp_cnt_next (temp_cnt_next),
    .hum_cnt_next  (hum_cnt_next)
  );

  sat_control #(
    .VALUE_BITS (VALUE_BITS),
    .CNT_BITS   (CNT_BITS),
    .SUM_BITS   (SUM_BITS)
  ) u_control (
    .clk         (clk),
    .rst         (rst),
    .commit      (advance),
    .target_temp (target_temp),
    .target_hum  (target_hum),
    .temp_sum    (temp_sum_next),
    .hum_sum     (hum_sum_next),
    .temp_cnt    (temp_cnt_next),
    .hum_cnt     (hum_cnt_next),
    .flags       (flags)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      op_status   <= op_result.status;
      slot_used   <= op_result.used;
      change_code <= flags.change;
      heating     <= flags.heating;
      humidifying <= flags.humidifying;
    end
  end

endmodule
`default_nettype wire

[rtl/sat_checker.sv]
// Port-level checks for the sensor-averaging thermostat, bound to the top level.
`default_nettype none
module sat_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              item_stall,
  input wire logic                              result_valid,
  input wire logic                              result_stall,
  input wire logic [1:0]                        op_status,
  input wire logic [sat_pkg::SLOT_USED_BITS-1:0] slot_used,
  input wire logic [1:0]                        change_code,
  input wire logic                              heating,
  input wire logic                              humidifying
);

  logic last_heat;
  logic last_hum;

  // Flags as of the last delivered word; both start off.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_heat <= 1'b0;
      last_hum  <= 1'b0;
    end else if (result_valid && !result_stall) begin
      last_heat <= heating;
      last_hum  <= humidifying;
    end
  end

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(op_status)
      && $stable(slot_used) && $stable(change_code) && $stable(heating)
      && $stable(humidifying))
    else $error("stalled result word changed");

  a_failed_op_no_slot: assert property (@(posedge clk) disable iff (rst)
    result_valid && op_status != sat_pkg::ST_OK |-> slot_used == '0)
    else $error("failed operation reports a slot");

  a_heat_flip_reported: assert property (@(posedge clk) disable iff (rst)
    result_valid && heating != last_heat |->
      change_code == sat_pkg::CHG_HEAT && humidifying == last_hum)
    else $error("heating changed without heating change code");

  a_hum_flip_reported: assert property (@(posedge clk) disable iff (rst)
    result_valid && humidifying != last_hum |-> change_code == sat_pkg::CHG_HUM)
    else $error("humidifier changed without humidifier change code");

  // Input stalls only behind a stalled result word
  a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> result_valid && result_stall)
    else $error("input stalled while the result side was free");

endmodule

bind sensor_average_thermostat sat_checker u_sat_checker (.*);
`default_nettype wire

[sim/tb.sv]
`timescale 1ns / 1ps
// Testbench for sensor_average_thermostat: directed and random words against a predictor.
module tb;

  localparam int SLOTS = 5;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LONG_HOLD = 80;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [7:0] KIND_NONE = 8'd0;
  localparam logic [7:0] KIND_BOGUS = 8'd3;
  localparam logic [7:0] KIND_MAX = 8'hFF;
  localparam logic [7:0] IDX_MAX = 8'hFF;
  localparam logic signed [15:0] VAL_MIN = 16'sh8000;
  localparam logic signed [15:0] VAL_MAX = 16'sh7FFF;

  typedef struct packed {
    logic [1:0] status;
    logic [3:0] used;
    logic [1:0] change;
    logic       heat;
    logic       hum;
  } report_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [sat_pkg::CFG_INDEX_BITS-1:0] cfg_index = sat_pkg::REG_TARGET_TEMP;
  logic [15:0] cfg_data = '0;
  logic item_valid = 1'b0;
  logic item_stall;
  logic [1:0] operation = sat_pkg::OP_EVAL;
  logic [7:0] sensor_kind = '0;
  logic [7:0] slot_index = '0;
  logic signed [15:0] sample_value = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  logic [1:0] op_status;
  logic [sat_pkg::SLOT_USED_BITS-1:0] slot_used;
  logic [1:0] change_code;
  logic heating;
  logic humidifying;

  sensor_average_thermostat #(
    .SENSOR_SLOTS(SLOTS),
    .VALUE_BITS(16)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .operation(operation),
    .sensor_kind(sensor_kind),
    .slot_index(slot_index),
    .sample_value(sample_value),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .op_status(op_status),
    .slot_used(slot_used),
    .change_code(change_code),
    .heating(heating),
    .humidifying(humidifying)
  );

  // Thermostat state as the predictor sees it
  int target_temp = sat_pkg::TARGET_TEMP_RESET;
  int target_hum = sat_pkg::TARGET_HUM_RESET;
  int slot_val [SLOTS];
  bit slot_hum [SLOTS];
  bit slot_on [SLOTS] = '{default: 1'b0};
  bit heater_on = 1'b0;
  bit humidifier_on = 1'b0;
  int temp_sum = 0;
  int hum_sum = 0;
  int temp_cnt = 0;
  int hum_cnt = 0;

  report_t reports_due[$];
  report_t oldest;
  int errors = 0;
  int stuck = 0;
  bit calm = 1'b0;
  bit long_hold = 1'b0;

  always #10 clk = ~clk;

  function automatic report_t compute_report(logic [1:0] op, logic [7:0] kind,
                                             logic [7:0] idx, logic signed [15:0] val);
    report_t r;
    int s;
    int i;
    bit now;
    s = val;
    r = '0;
    if (op == sat_pkg::OP_ADD) begin
      if (kind != sat_pkg::KIND_TEMP && kind != sat_pkg::KIND_HUM) begin
        r.status = sat_pkg::ST_BAD_KIND;
      end else begin
        r.status = sat_pkg::ST_FULL;
        for (i = 0; i < SLOTS; i++) begin
          if (r.status == sat_pkg::ST_FULL && !slot_on[i]) begin
            slot_on[i] = 1'b1;
            slot_hum[i] = (kind == sat_pkg::KIND_HUM);
            slot_val[i] = s;
            if (kind == sat_pkg::KIND_HUM) begin
              hum_sum += s;
              hum_cnt++;
            end else begin
              temp_sum += s;
              temp_cnt++;
            end
            r.status = sat_pkg::ST_OK;
            r.used = 4'(i);
          end
        end
      end
    end else if (op == sat_pkg::OP_UPDATE) begin
      if (idx >= SLOTS || !slot_on[idx]) begin
        r.status = sat_pkg::ST_BAD_SLOT;
      end else begin
        if (slot_hum[idx]) hum_sum += s - slot_val[idx];
        else temp_sum += s - slot_val[idx];
        slot_val[idx] = s;
        r.used = 4'(idx);
      end
    end
    // Heating goes first; a heating change skips the humidity check
    r.change = sat_pkg::CHG_NONE;
    if (temp_cnt != 0) begin
      now = temp_sum < target_temp * temp_cnt;
      if (now != heater_on) r.change = sat_pkg::CHG_HEAT;
      heater_on = now;
    end
    if (r.change == sat_pkg::CHG_NONE && hum_cnt != 0) begin
      now = hum_sum < target_hum * hum_cnt;
      if (now != humidifier_on) r.change = sat_pkg::CHG_HUM;
      humidifier_on = now;
    end
    r.heat = heater_on;
    r.hum = humidifier_on;
    return r;
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      if (reports_due.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        oldest = reports_due.pop_front();
        check_field("op_status", oldest.status, op_status);
        check_field("slot_used", oldest.used, slot_used);
        check_field("change_code", oldest.change, change_code);
        check_field("heating", oldest.heat, heating);
        check_field("humidifying", oldest.hum, humidifying);
      end
    end
  end

  always @(posedge clk) begin
    if ((item_valid && !item_stall) || (result_valid && !result_stall)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Receiver: random stall bursts, plus one long hold on request
  always begin
    @(negedge clk);
    if (long_hold) begin
      result_stall <= 1'b1;
      repeat (LONG_HOLD) @(negedge clk);
      result_stall <= 1'b0;
      long_hold = 1'b0;
    end else if (!calm && !rst && $urandom_range(0, 5) == 0) begin
      result_stall <= 1'b1;
      repeat ($urandom_range(1, 19)) @(negedge clk);
      result_stall <= 1'b0;
    end
  end

  task automatic send_word(logic [1:0] op, logic [7:0] kind, logic [7:0] idx,
                           logic signed [15:0] val);
    @(negedge clk);
    item_valid <= 1'b1;
    operation <= op;
    sensor_kind <= kind;
    slot_index <= idx;
    sample_value <= val;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    reports_due.push_back(compute_report(op, kind, idx, val));
  endtask

  task automatic idle_sender(int n);
    @(negedge clk);
    item_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic maybe_idle();
    if (!calm && $urandom_range(0, 5) == 0) idle_sender($urandom_range(1, 19));
  endtask

  // Hold the sender until every outstanding word has come back
  task automatic drain();
    @(negedge clk);
    item_valid <= 1'b0;
    while (reports_due.size() != 0) @(negedge clk);
  endtask

  task automatic write_target(logic [sat_pkg::CFG_INDEX_BITS-1:0] idx,
                              logic signed [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == sat_pkg::REG_TARGET_TEMP) target_temp = val;
    else target_hum = val;
  endtask

  task automatic random_word();
    logic [1:0] op;
    logic [7:0] kind;
    logic [7:0] idx;
    logic signed [15:0] val;
    int pick;
    int slot;
    int v;
    pick = $urandom_range(0, 19);
    op = 2'($urandom_range(0, 3));
    kind = 8'($urandom_range(0, 255));
    idx = 8'($urandom_range(0, 255));
    val = 16'($urandom_range(0, 65535));
    if (pick < 13) begin
      slot = $urandom_range(0, SLOTS - 1);
      op = sat_pkg::OP_UPDATE;
      idx = 8'(slot);
      // Keep most samples close to the target so the averages cross it
      if (pick < 10) begin
        v = (slot_hum[slot] ? target_hum : target_temp) + int'($urandom_range(0, 1024)) - 512;
        if (v > VAL_MAX) v = VAL_MAX;
        if (v < VAL_MIN) v = VAL_MIN;
        val = 16'(v);
      end
    end else if (pick < 15) begin
      op = sat_pkg::OP_EVAL;
    end else if (pick < 17) begin
      op = sat_pkg::OP_ADD;
    end
    send_word(op, kind, idx, val);
  endtask

  task automatic test_empty_table();
    send_word(sat_pkg::OP_EVAL, sat_pkg::KIND_TEMP, 8'd0, 16'sd0);
    send_word(OP_SPARE, sat_pkg::KIND_HUM, 8'd4, VAL_MAX);
    send_word(sat_pkg::OP_UPDATE, sat_pkg::KIND_TEMP, 8'd0, VAL_MIN);
    send_word(sat_pkg::OP_UPDATE, sat_pkg::KIND_HUM, IDX_MAX, VAL_MAX);
    send_word(sat_pkg::OP_ADD, KIND_NONE, 8'd0, VAL_MAX);
    send_word(sat_pkg::OP_ADD, KIND_BOGUS, IDX_MAX, VAL_MIN);
    send_word(sat_pkg::OP_ADD, KIND_MAX, 8'd1, 16'sd0);
  endtask

  task automatic test_fill_table();
    send_word(sat_pkg::OP_ADD, sat_pkg::KIND_TEMP, IDX_MAX, VAL_MIN);
    send_word(sat_pkg::OP_ADD, sat_pkg::KIND_HUM, 8'd0, VAL_MAX);
    send_word(sat_pkg::OP_UPDATE, KIND_NONE, 8'd1, VAL_MIN);
    send_word(sat_pkg::OP_ADD, sat_pkg::KIND_TEMP, 8'd0, VAL_MAX);
    send_word(sat_pkg::OP_UPDATE, KIND_MAX, 8'd0, VAL_MAX);
    send_word(sat_pkg::OP_EVAL, KIND_MAX, IDX_MAX, VAL_MIN);
    send_word(sat_pkg::OP_ADD, sat_pkg::KIND_HUM, 8'd0, 16'sd0);
    send_word(sat_pkg::OP_ADD, sat_pkg::KIND_TEMP, 8'd0, 16'sh5555);
    send_word(sat_pkg::OP_ADD, sat_pkg::KIND_TEMP, 8'd0, 16'sd0);
    send_word(sat_pkg::OP_ADD, KIND_BOGUS, 8'd0, 16'sd0);
    send_word(sat_pkg::OP_UPDATE, sat_pkg::KIND_TEMP, 8'(SLOTS), VAL_MAX);
    send_word(sat_pkg::OP_UPDATE, sat_pkg::KIND_HUM, 8'd4, 16'shAAAA);
    send_word(OP_SPARE, KIND_BOGUS, 8'd2, VAL_MIN);
    send_word(sat_pkg::OP_UPDATE, sat_pkg::KIND_TEMP, 8'd2, VAL_MIN);
  endtask

  task automatic test_target_extremes();
    drain();
    write_target(sat_pkg::REG_TARGET_TEMP, VAL_MAX);
    write_target(sat_pkg::REG_TARGET_HUM, VAL_MIN);
    send_word(sat_pkg::OP_EVAL, sat_pkg::KIND_TEMP, 8'd0, 16'sd0);
    send_word(sat_pkg::OP_EVAL, sat_pkg::KIND_TEMP, 8'd0, 16'sd0);
    drain();
    write_target(sat_pkg::REG_TARGET_TEMP, VAL_MIN);
    write_target(sat_pkg::REG_TARGET_HUM, VAL_MAX);
    send_word(sat_pkg::OP_EVAL, sat_pkg::KIND_HUM, 8'd0, 16'sd0);
    send_word(sat_pkg::OP_EVAL, sat_pkg::KIND_HUM, 8'd0, 16'sd0);
  endtask

  task automatic test_random_phases();
    int phase;
    int n;
    for (phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: begin
          write_target(sat_pkg::REG_TARGET_TEMP, 16'(sat_pkg::TARGET_TEMP_RESET));
          write_target(sat_pkg::REG_TARGET_HUM, 16'(sat_pkg::TARGET_HUM_RESET));
        end
        1: begin
          write_target(sat_pkg::REG_TARGET_TEMP, VAL_MIN);
          write_target(sat_pkg::REG_TARGET_HUM, VAL_MAX);
        end
        2: begin
          write_target(sat_pkg::REG_TARGET_TEMP, VAL_MAX);
          write_target(sat_pkg::REG_TARGET_HUM, VAL_MIN);
        end
        default: begin
          write_target(sat_pkg::REG_TARGET_TEMP, 16'($urandom_range(0, 65535)));
          write_target(sat_pkg::REG_TARGET_HUM, 16'($urandom_range(0, 65535)));
        end
      endcase
      for (n = 0; n < 55; n++) begin
        maybe_idle();
        random_word();
      end
    end
  endtask

  // Stall the result side long enough that both stages fill and the input stalls
  task automatic test_backpressure();
    drain();
    long_hold = 1'b1;
    repeat (25) random_word();
    drain();
  endtask

  task automatic test_pause_and_resume();
    repeat (15) begin
      maybe_idle();
      random_word();
    end
    drain();
    repeat (15) begin
      maybe_idle();
      random_word();
    end
  endtask

  task automatic test_steady_tail();
    calm = 1'b1;
    repeat (60) random_word();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_fill_table();
    test_target_extremes();
    test_random_phases();
    test_backpressure();
    test_pause_and_resume();
    test_steady_tail();
    drain();
    repeat (4) @(negedge clk);
    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule

[sim.f]
rtl/sat_pkg.sv
rtl/sat_table.sv
rtl/sat_control.sv
rtl/sensor_average_thermostat.sv
rtl/sat_checker.sv
sim/tb.sv
